// ----- src/tked_pkg.sv -----
// ----------------------------------------------------------------------------
// tked_pkg: shared types and constants for the terminal key escape decoder
// Beat payload structs, key class and named key codes, and the final-byte map.
// ----------------------------------------------------------------------------
package tked_pkg;

  localparam int unsigned DEF_MAX_SEQ_BYTES = 16;
  localparam logic [7:0]  DEF_TIMEOUT_TICKS = 8'd15;

  // input opcodes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // key classes
  localparam logic [2:0] KC_CHAR  = 3'd0;
  localparam logic [2:0] KC_NAMED = 3'd1;
  localparam logic [2:0] KC_ESC   = 3'd2;
  localparam logic [2:0] KC_ALT   = 3'd3;
  localparam logic [2:0] KC_NONE  = 3'd4;

  // named keys
  localparam logic [4:0] NK_UP    = 5'd0;
  localparam logic [4:0] NK_DOWN  = 5'd1;
  localparam logic [4:0] NK_RIGHT = 5'd2;
  localparam logic [4:0] NK_LEFT  = 5'd3;
  localparam logic [4:0] NK_HOME  = 5'd4;
  localparam logic [4:0] NK_END   = 5'd5;
  localparam logic [4:0] NK_INS   = 5'd6;
  localparam logic [4:0] NK_DEL   = 5'd7;
  localparam logic [4:0] NK_PGUP  = 5'd8;
  localparam logic [4:0] NK_PGDN  = 5'd9;
  localparam logic [4:0] NK_F1    = 5'd10;
  localparam logic [4:0] NK_LAST  = 5'd21;

  // byte values
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_BS     = 8'd8;
  localparam logic [7:0] CH_CTRL_Z = 8'd26;
  localparam logic [7:0] CH_ESC    = 8'd27;
  localparam logic [7:0] CH_DEL    = 8'd127;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_SS3    = 8'h4F;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CTRL_OFS  = 8'd96;  // 'a' - 1

  typedef struct packed {
    logic       opcode;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0] key_class;
    logic [7:0] char_code;
    logic [4:0] named_key;
    logic       shift_flag;
    logic       alt_flag;
    logic       ctrl_flag;
  } out_item_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] key;
  } key_hit_t;

  // Final byte of a CSI/SS3 sequence to a named key.
  function automatic key_hit_t final_key(logic [7:0] c, logic ss3, logic [7:0] num);
    key_hit_t r;
    r = '{hit: 1'b1, key: NK_UP};
    case (c)
      8'h41: r.key = NK_UP;     // A
      8'h42: r.key = NK_DOWN;   // B
      8'h43: r.key = NK_RIGHT;  // C
      8'h44: r.key = NK_LEFT;   // D
      8'h48: r.key = NK_HOME;   // H
      8'h46: r.key = NK_END;    // F
      8'h50, 8'h51, 8'h52, 8'h53: begin  // P..S, SS3 only
        r.hit = ss3;
        r.key = NK_F1 + c[4:0] - 5'h10;
      end
      CH_TILDE: begin
        case (num)
          8'd1, 8'd7: r.key = NK_HOME;
          8'd2:       r.key = NK_INS;
          8'd3:       r.key = NK_DEL;
          8'd4, 8'd8: r.key = NK_END;
          8'd5:       r.key = NK_PGUP;
          8'd6:       r.key = NK_PGDN;
          8'd11:      r.key = NK_F1;
          8'd12:      r.key = NK_F1 + 5'd1;
          8'd13:      r.key = NK_F1 + 5'd2;
          8'd14:      r.key = NK_F1 + 5'd3;
          8'd15:      r.key = NK_F1 + 5'd4;
          8'd17:      r.key = NK_F1 + 5'd5;
          8'd18:      r.key = NK_F1 + 5'd6;
          8'd19:      r.key = NK_F1 + 5'd7;
          8'd20:      r.key = NK_F1 + 5'd8;
          8'd21:      r.key = NK_F1 + 5'd9;
          8'd23:      r.key = NK_F1 + 5'd10;
          8'd24:      r.key = NK_F1 + 5'd11;
          default:    r.hit = 1'b0;
        endcase
      end
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  // Decimal accumulate, saturating at 255.
  function automatic logic [7:0] sat_digit(logic [7:0] v, logic [3:0] d);
    logic [11:0] s;
    s = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {8'd0, d};
    return (s > 12'd255) ? 8'hFF : s[7:0];
  endfunction

endpackage

// ----- src/terminal_key_escape_decoder_top.sv -----
// ----------------------------------------------------------------------------
// terminal_key_escape_decoder_top: serial-terminal byte to key event decoder
// Parses plain bytes, control codes, ESC prefixes and CSI/SS3 sequences.
// ----------------------------------------------------------------------------
// Each input beat is either a received byte or one elapsed time tick. The
// decoder takes one beat per clock and answers with at most one key event,
// registered in the cycle after the beat is accepted. All parsing is a single
// combinational pass from the parser state and the input beat into the state
// registers and the result register, so throughput is one beat per cycle;
// only a result held by out_stall holds off the input (in_stall is the result
// register full and stalled). Beats that give no event (ESC, '[' , digits,
// ticks before the timeout) are accepted like any other beat. The user must
// write the timeout register through cfg_* only while the decoder is idle;
// the block does not enforce this, and cfg_ready is always high. Sequences
// that reach MAX_SEQ_BYTES digit/';' bytes end as a none event.
// ----------------------------------------------------------------------------
module terminal_key_escape_decoder_top #(
  parameter int unsigned MAX_SEQ_BYTES = tked_pkg::DEF_MAX_SEQ_BYTES
) (
  input  logic                clk,
  input  logic                rst_n,
  // input beats
  input  logic                in_valid,
  output logic                in_stall,
  input  tked_pkg::in_item_t  in_data,
  // key events
  output logic                out_valid,
  input  logic                out_stall,
  output tked_pkg::out_item_t out_data,
  // timeout register
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);

  localparam int unsigned SeqW = $clog2(MAX_SEQ_BYTES + 1);
  localparam logic [SeqW-1:0] SeqMax = SeqW'(MAX_SEQ_BYTES);

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,  // plain bytes
    PH_ESC  = 3'b010,  // ESC seen
    PH_SEQ  = 3'b100   // inside CSI/SS3
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic                ss3_r, ss3_nxt;
  logic [7:0]          first_r, first_nxt;
  logic [7:0]          mod_r, mod_nxt;
  logic                semi_r, semi_nxt;
  logic [SeqW-1:0]     seq_cnt_r, seq_cnt_nxt;
  logic [7:0]          ticks_r, ticks_nxt;
  logic [7:0]          timeout_r;

  logic                out_valid_r;
  tked_pkg::out_item_t out_data_r;

  logic                in_acc;
  logic                emit;
  tked_pkg::out_item_t res;
  tked_pkg::key_hit_t  fk;
  logic [7:0]          c;
  logic [7:0]          m;
  logic                is_digit;

  // Output register frees when empty or being taken this cycle.
  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign c        = in_data.byte_value;
  assign is_digit = (c >= tked_pkg::CH_ZERO) && (c <= tked_pkg::CH_NINE);
  assign m        = mod_r - 8'd1;
  assign fk       = tked_pkg::final_key(c, ss3_r, first_r);

  // Parser step
  always_comb begin
    phase_nxt   = phase_r;
    ss3_nxt     = ss3_r;
    first_nxt   = first_r;
    mod_nxt     = mod_r;
    semi_nxt    = semi_r;
    seq_cnt_nxt = seq_cnt_r;
    ticks_nxt   = ticks_r;
    emit        = 1'b0;
    res         = '0;

    if (in_data.opcode == tked_pkg::OP_TICK) begin
      if (phase_r != PH_IDLE) begin
        ticks_nxt = (ticks_r == 8'hFF) ? 8'hFF : ticks_r + 8'd1;
        if (ticks_nxt >= timeout_r) begin
          phase_nxt     = PH_IDLE;
          emit          = 1'b1;
          res.key_class = tked_pkg::KC_ESC;
          res.char_code = tked_pkg::CH_ESC;
        end
      end
    end else begin
      case (phase_r)
        PH_IDLE: begin
          emit = 1'b1;
          res.key_class = tked_pkg::KC_CHAR;
          if (c >= 8'd1 && c <= tked_pkg::CH_CTRL_Z && c != tked_pkg::CH_LF &&
              c != tked_pkg::CH_TAB && c != tked_pkg::CH_BS) begin
            res.char_code = c + tked_pkg::CTRL_OFS;
            res.ctrl_flag = 1'b1;
          end else if (c == tked_pkg::CH_DEL) begin
            res.char_code = tked_pkg::CH_BS;
          end else if (c == tked_pkg::CH_ESC) begin
            emit      = 1'b0;
            phase_nxt = PH_ESC;
            ticks_nxt = 8'd0;
          end else begin
            res.char_code = c;
          end
        end
        PH_ESC: begin
          if (c != tked_pkg::CH_LBRACK && c != tked_pkg::CH_SS3) begin
            phase_nxt     = PH_IDLE;
            emit          = 1'b1;
            res.key_class = tked_pkg::KC_ALT;
            res.char_code = c;
            res.alt_flag  = 1'b1;
          end else begin
            phase_nxt   = PH_SEQ;
            ss3_nxt     = (c == tked_pkg::CH_SS3);
            first_nxt   = 8'd0;
            mod_nxt     = 8'd0;
            semi_nxt    = 1'b0;
            seq_cnt_nxt = '0;
          end
        end
        default: begin  // PH_SEQ
          if (is_digit || c == tked_pkg::CH_SEMI) begin
            if (c == tked_pkg::CH_SEMI) begin
              semi_nxt = 1'b1;
            end else if (semi_r) begin
              mod_nxt = tked_pkg::sat_digit(mod_r, c[3:0]);
            end else begin
              first_nxt = tked_pkg::sat_digit(first_r, c[3:0]);
            end
            seq_cnt_nxt = seq_cnt_r + SeqW'(1);
            if (seq_cnt_nxt >= SeqMax) begin
              phase_nxt     = PH_IDLE;
              emit          = 1'b1;
              res.key_class = tked_pkg::KC_NONE;
            end
          end else begin
            phase_nxt = PH_IDLE;
            emit      = 1'b1;
            if (fk.hit) begin
              res.key_class = tked_pkg::KC_NAMED;
              res.named_key = fk.key;
              // xterm modifier 2..8 -> flags of (mod - 1)
              if (mod_r >= 8'd2 && mod_r <= 8'd8) begin
                res.shift_flag = m[0];
                res.alt_flag   = m[1];
                res.ctrl_flag  = m[2];
              end
            end else begin
              res.key_class = tked_pkg::KC_NONE;
            end
          end
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      ss3_r       <= 1'b0;
      first_r     <= 8'd0;
      mod_r       <= 8'd0;
      semi_r      <= 1'b0;
      seq_cnt_r   <= '0;
      ticks_r     <= 8'd0;
      timeout_r   <= tked_pkg::DEF_TIMEOUT_TICKS;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_r   <= phase_nxt;
        ss3_r     <= ss3_nxt;
        first_r   <= first_nxt;
        mod_r     <= mod_nxt;
        semi_r    <= semi_nxt;
        seq_cnt_r <= seq_cnt_nxt;
        ticks_r   <= ticks_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        timeout_r <= cfg_data;
      end
      if (!out_valid_r || !out_stall) begin
        out_valid_r <= in_acc & emit;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      out_data_r <= res;
    end
  end

`ifndef SYNTHESIS
  // ESC byte in idle opens a sequence with no event
  a_esc_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && phase_r == PH_IDLE && in_data.opcode == tked_pkg::OP_BYTE &&
    in_data.byte_value == tked_pkg::CH_ESC |=> phase_r == PH_ESC && !out_valid_r)
    else $error("ESC did not open a sequence");

  // a tick while idle gives no event
  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && phase_r == PH_IDLE && in_data.opcode == tked_pkg::OP_TICK |=> !out_valid_r)
    else $error("tick in idle produced an event");

  // the sequence counter never reaches its limit while in a sequence
  a_seq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SEQ |-> seq_cnt_r < SeqMax)
    else $error("sequence byte count overran");

  // lone escape always carries ESC
  a_lone_esc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.key_class == tked_pkg::KC_ESC |->
      out_data_r.char_code == tked_pkg::CH_ESC)
    else $error("lone escape with wrong char code");

  // named key stays in range
  a_named_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.key_class == tked_pkg::KC_NAMED |->
      out_data_r.named_key <= tked_pkg::NK_LAST)
    else $error("named key out of range");
`endif

endmodule
